>>> rtl/assert_macros.svh
// Assertion macros shared by the phaser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SAP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phaser assertion failed");

// Next-cycle implication, disabled during reset.
`define SAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phaser assertion failed");

`endif

>>> rtl/sap_pkg.sv
// Shared types, constants and helper functions of the stereo allpass phaser.
`default_nettype none
package sap_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int LFO_BITS    = 16;
    localparam int CFG_DATA_W  = 18;
    localparam int FREQ_W      = 34;

    localparam logic [17:0]        RATE_DEFAULT = 18'd48000;
    localparam logic [16:0]        UNITY_Q16    = 17'd65536;
    localparam logic signed [15:0] GAIN_LIMIT   = 16'sd31130;
    // ceil(2^31 / 100): exact floor(x / 100) for x below 2^24
    localparam logic [24:0]        RECIP_100    = 25'd21474837;
    localparam longint             PI_Q30       = 64'sd3373259426;
    localparam longint             Q30_ONE      = 64'sd1073741824;

    typedef enum logic [2:0] {
        REG_SAMPLE_RATE = 3'd0,
        REG_MIN_HZ      = 3'd1,
        REG_MAX_HZ      = 3'd2,
        REG_WET_LEVEL   = 3'd3,
        REG_LOOP_GAIN   = 3'd4,
        REG_MIX_MODE    = 3'd5,
        REG_STAGE_COUNT = 3'd6,
        REG_LOOP_POLE   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
        logic signed [LFO_BITS-1:0]    lfo_left;
        logic signed [LFO_BITS-1:0]    lfo_right;
        logic                          stereo;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } frame_out_t;

    // Settings after range fixing, shared by both lanes
    typedef struct packed {
        logic [17:0]        fs;
        logic [16:0]        min_hz;
        logic [16:0]        max_hz;
        logic [16:0]        wet;
        logic [16:0]        dry;
        logic signed [15:0] gain;
        logic [15:0]        pole;
    } lane_cfg_t;

    typedef struct packed {
        logic start;
        logic release_lane;
    } lane_ctrl_t;

    typedef struct packed {
        logic active;
        logic done;
    } lane_stat_t;

    typedef enum logic [4:0] {
        LS_IDLE,
        LS_NYQ_MUL,
        LS_NYQ_SCALE,
        LS_SPAN,
        LS_FREQ,
        LS_DIV_LOAD,
        LS_DIV,
        LS_ROM,
        LS_FEED_MUL,
        LS_FEED_ADD,
        LS_STG_MUL,
        LS_STG_ADD,
        LS_RET_MUL,
        LS_RET_ADD,
        LS_MIX_MUL,
        LS_MIX_ADD,
        LS_DONE
    } lane_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = (72'sd1 <<< (SAMPLE_BITS - 1)) - 72'sd1;
        lo = -(72'sd1 <<< (SAMPLE_BITS - 1));
        if (v > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (v < lo)
            return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic longint mulq30(input longint a, input longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // Truncating signed quotient by shift and subtract; table build only
    function automatic longint div_trunc(input longint num, input longint den);
        logic [63:0] n_mag;
        logic [63:0] d_mag;
        logic [63:0] rem;
        logic [63:0] quo;
        n_mag = (num < 0) ? 64'(-num) : 64'(num);
        d_mag = (den < 0) ? 64'(-den) : 64'(den);
        rem   = '0;
        quo   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], n_mag[i]};
            if (rem >= d_mag)
            begin
                rem    = rem - d_mag;
                quo[i] = 1'b1;
            end
        end
        return ((num < 0) != (den < 0)) ? -longint'(quo) : longint'(quo);
    endfunction

    // tan of a Q30 angle from truncated Taylor series; table build only
    function automatic longint coeff_from_angle(input longint th);
        longint st;
        longint ss;
        longint ct;
        longint cs;
        st = th;
        ss = th;
        ct = Q30_ONE;
        cs = Q30_ONE;
        for (int n = 1; n <= 6; n++) begin
            st = div_trunc(-mulq30(mulq30(st, th), th), longint'((2 * n) * (2 * n + 1)));
            ss = ss + st;
            ct = div_trunc(-mulq30(mulq30(ct, th), th), longint'((2 * n - 1) * (2 * n)));
            cs = cs + ct;
        end
        if (cs <= 0)
            cs = 1;
        return div_trunc(ss * Q30_ONE, cs);
    endfunction

endpackage
`default_nettype wire

>>> rtl/sap_coeff_rom.sv
// Allpass coefficient table with registered read.
`default_nettype none
module sap_coeff_rom #(
    parameter int COEFF_TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic [$clog2(COEFF_TABLE_DEPTH)-1:0] addr,
    output logic signed [31:0]                   data
);
    import sap_pkg::*;

    logic signed [31:0] rom_table [COEFF_TABLE_DEPTH];
    logic signed [31:0] data_reg;

    for (genvar g = 0; g < COEFF_TABLE_DEPTH; g++) begin : g_entry
        localparam longint Angle =
            PI_Q30 / 4 - (PI_Q30 * longint'(g)) / (2 * COEFF_TABLE_DEPTH);
        localparam logic signed [31:0] Coeff = 32'(coeff_from_angle(Angle));
        assign rom_table[g] = Coeff;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_table[addr];
    end

    assign data = data_reg;

endmodule
`default_nettype wire

>>> rtl/sap_lane.sv
// One channel of the phaser: sweep index, coefficient, feedback, stage walk, mix.
`default_nettype none
module sap_lane #(
    parameter int MAX_STAGES        = 12,
    parameter int COEFF_TABLE_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sap_pkg::lane_cfg_t                     cfg,
    input  logic [$clog2(MAX_STAGES+1)-1:0]        stage_count,
    input  sap_pkg::lane_ctrl_t                    ctrl,
    input  logic signed [sap_pkg::SAMPLE_BITS-1:0] sample,
    input  logic signed [sap_pkg::LFO_BITS-1:0]    lfo,
    output sap_pkg::lane_stat_t                    stat,
    output logic signed [sap_pkg::SAMPLE_BITS-1:0] result
);
    import sap_pkg::*;

    localparam int CntW     = $clog2(MAX_STAGES + 1);
    localparam int IdxW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int AddrW    = $clog2(COEFF_TABLE_DEPTH);
    localparam int TwoDepth = 2 * COEFF_TABLE_DEPTH;
    localparam int QuoW     = $clog2(TwoDepth) + 1;
    localparam int NumW     = FREQ_W + QuoW;
    localparam int DivCntW  = $clog2(QuoW);
    localparam logic [QuoW-1:0] KMax = QuoW'(COEFF_TABLE_DEPTH - 1);

    lane_state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [LFO_BITS-1:0]    lfo_reg;
    logic [23:0]                   p49_reg;
    logic [17:0]                   nyq_reg;
    logic [16:0]                   lo_reg;
    logic [16:0]                   span_reg;
    logic [FREQ_W-1:0]             freq_reg;
    logic [FREQ_W-1:0]             rem_reg;
    logic [QuoW-1:0]               low_reg;
    logic [QuoW-1:0]               q_reg;
    logic [DivCntW-1:0]            dcnt_reg;
    logic [AddrW-1:0]              k_reg;
    logic signed [31:0]            c_reg;
    logic signed [65:0]            prod_reg;
    logic signed [31:0]            y_reg;
    logic [IdxW-1:0]               idx_reg;
    logic signed [41:0]            pd_reg;
    logic signed [49:0]            pw_reg;
    logic signed [SAMPLE_BITS-1:0] result_reg;
    logic signed [31:0]            in_taps_reg  [MAX_STAGES];
    logic signed [31:0]            out_taps_reg [MAX_STAGES];
    logic signed [31:0]            hp_in_reg;
    logic signed [31:0]            hp_out_reg;

    logic signed [31:0] rom_data;

    logic [48:0]         nyq_full;
    logic [17:0]         nyq_raw;
    logic [17:0]         lo_c;
    logic [17:0]         hi_c;
    logic [17:0]         lo_fin;
    logic [15:0]         lfo_u;
    logic [FREQ_W-1:0]   freq_calc;
    logic [NumW-1:0]     num_full;
    logic [FREQ_W-1:0]   den;
    logic [FREQ_W:0]     trial;
    logic                ge;
    logic [FREQ_W-1:0]   rem_step;
    logic [QuoW-1:0]     q_step;
    logic [AddrW-1:0]    k_calc;
    logic signed [31:0]  x_tap;
    logic signed [31:0]  z_tap;
    logic signed [32:0]  diff;
    logic signed [65:0]  stg_prod;
    logic signed [65:0]  feed_prod;
    logic signed [33:0]  ret_sum;
    logic signed [65:0]  ret_prod;
    logic signed [41:0]  pd_calc;
    logic signed [49:0]  pw_calc;
    logic signed [65:0]  r15;
    logic signed [65:0]  r16;
    logic signed [65:0]  r30;
    logic signed [31:0]  feed_y;
    logic signed [31:0]  stage_out;
    logic signed [31:0]  ret_b;
    logic signed [50:0]  mix_sum;
    logic signed [50:0]  mix_r;
    logic                last_stage;

    sap_coeff_rom #(
        .COEFF_TABLE_DEPTH(COEFF_TABLE_DEPTH)
    ) u_rom (
        .clk (clk),
        .addr(k_reg),
        .data(rom_data)
    );

    always_comb
    begin
        nyq_full  = 49'(p49_reg) * 49'(RECIP_100);
        nyq_raw   = nyq_full[48:31];
        lo_c      = (cfg.min_hz == 17'd0) ? 18'd1 :
                    (({1'b0, cfg.min_hz} > nyq_reg) ? nyq_reg : {1'b0, cfg.min_hz});
        hi_c      = (cfg.max_hz == 17'd0) ? 18'd1 :
                    (({1'b0, cfg.max_hz} > nyq_reg) ? nyq_reg : {1'b0, cfg.max_hz});
        lo_fin    = (lo_c > hi_c) ? hi_c : lo_c;
        lfo_u     = {~lfo_reg[LFO_BITS-1], lfo_reg[LFO_BITS-2:0]};
        freq_calc = {1'b0, lo_reg, 16'd0} + FREQ_W'(span_reg * lfo_u);
        num_full  = NumW'(freq_reg) * NumW'(TwoDepth);
        den       = {cfg.fs, 16'd0};
        trial     = {rem_reg, low_reg[QuoW-1]};
        ge        = (trial >= {1'b0, den});
        rem_step  = ge ? FREQ_W'(trial - {1'b0, den}) : trial[FREQ_W-1:0];
        q_step    = {q_reg[QuoW-2:0], ge};
        k_calc    = (q_step > KMax) ? KMax[AddrW-1:0] : q_step[AddrW-1:0];

        x_tap     = in_taps_reg[idx_reg];
        z_tap     = out_taps_reg[idx_reg];
        diff      = 33'(z_tap) - 33'(y_reg);
        stg_prod  = c_reg * diff;
        feed_prod = cfg.gain * hp_out_reg;
        ret_sum   = 34'(hp_out_reg) + 34'(y_reg) - 34'(hp_in_reg);
        ret_prod  = $signed({1'b0, cfg.pole}) * ret_sum;
        pd_calc   = $signed({1'b0, cfg.dry}) * sample_reg;
        pw_calc   = $signed({1'b0, cfg.wet}) * y_reg;

        // round to nearest, ties up: add half then floor-shift
        r15       = (prod_reg + (66'sd1 <<< 14)) >>> 15;
        r16       = (prod_reg + (66'sd1 <<< 15)) >>> 16;
        r30       = (prod_reg + (66'sd1 <<< 29)) >>> 30;
        feed_y    = sat32(72'(sample_reg) + 72'(r15));
        stage_out = sat32(72'(x_tap) + 72'(r30));
        ret_b     = sat32(72'(r16));
        mix_sum   = 51'(pd_reg) + 51'(pw_reg);
        mix_r     = (mix_sum + (51'sd1 <<< 15)) >>> 16;

        last_stage = ((CntW'(idx_reg) + CntW'(1)) == stage_count);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LS_IDLE:      if (ctrl.start) state_next = LS_NYQ_MUL;
            LS_NYQ_MUL:   state_next = LS_NYQ_SCALE;
            LS_NYQ_SCALE: state_next = LS_SPAN;
            LS_SPAN:      state_next = LS_FREQ;
            LS_FREQ:      state_next = LS_DIV_LOAD;
            LS_DIV_LOAD:  state_next = LS_DIV;
            LS_DIV:       if (dcnt_reg == '0) state_next = LS_ROM;
            LS_ROM:       state_next = LS_FEED_MUL;
            LS_FEED_MUL:  state_next = LS_FEED_ADD;
            LS_FEED_ADD:  state_next = LS_STG_MUL;
            LS_STG_MUL:   state_next = LS_STG_ADD;
            LS_STG_ADD:   state_next = last_stage ? LS_RET_MUL : LS_STG_MUL;
            LS_RET_MUL:   state_next = LS_RET_ADD;
            LS_RET_ADD:   state_next = LS_MIX_MUL;
            LS_MIX_MUL:   state_next = LS_MIX_ADD;
            LS_MIX_ADD:   state_next = LS_DONE;
            LS_DONE:      if (ctrl.release_lane) state_next = LS_IDLE;
            default:      state_next = LS_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.active = (state_reg != LS_IDLE);
        stat.done   = (state_reg == LS_DONE);
        result      = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LS_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            LS_IDLE:
            begin
                if (ctrl.start)
                begin
                    sample_reg <= sample;
                    lfo_reg    <= lfo;
                end
            end
            LS_NYQ_MUL:   p49_reg <= 24'(cfg.fs * 6'd49);
            LS_NYQ_SCALE: nyq_reg <= (nyq_raw == 18'd0) ? 18'd1 : nyq_raw;
            LS_SPAN:
            begin
                lo_reg   <= lo_fin[16:0];
                span_reg <= 17'(hi_c - lo_fin);
            end
            LS_FREQ:      freq_reg <= freq_calc;
            LS_DIV_LOAD:
            begin
                rem_reg  <= num_full[NumW-1:QuoW];
                low_reg  <= num_full[QuoW-1:0];
                q_reg    <= '0;
                dcnt_reg <= DivCntW'(QuoW - 1);
            end
            LS_DIV:
            begin
                rem_reg  <= rem_step;
                low_reg  <= {low_reg[QuoW-2:0], 1'b0};
                q_reg    <= q_step;
                dcnt_reg <= dcnt_reg - DivCntW'(1);
                k_reg    <= k_calc;
            end
            LS_FEED_MUL:
            begin
                c_reg    <= rom_data;
                prod_reg <= feed_prod;
            end
            LS_FEED_ADD:
            begin
                y_reg   <= feed_y;
                idx_reg <= '0;
            end
            LS_STG_MUL:   prod_reg <= stg_prod;
            LS_STG_ADD:
            begin
                y_reg   <= stage_out;
                idx_reg <= idx_reg + IdxW'(1);
            end
            LS_RET_MUL:   prod_reg <= ret_prod;
            LS_MIX_MUL:
            begin
                pd_reg <= pd_calc;
                pw_reg <= pw_calc;
            end
            LS_MIX_ADD:   result_reg <= sat_sample(72'(mix_r));
            default: ;
        endcase
    end

    // filter state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                in_taps_reg[i]  <= '0;
                out_taps_reg[i] <= '0;
            end
            hp_in_reg  <= '0;
            hp_out_reg <= '0;
        end
        else if (state_reg == LS_STG_ADD)
        begin
            in_taps_reg[idx_reg]  <= y_reg;
            out_taps_reg[idx_reg] <= stage_out;
        end
        else if (state_reg == LS_RET_ADD)
        begin
            hp_in_reg  <= y_reg;
            hp_out_reg <= ret_b;
        end
    end

endmodule
`default_nettype wire

>>> rtl/stereo_allpass_phaser.sv
// Top level of the stereo allpass phaser: config registers, two lanes, output stage.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | request   | in_valid / in_stall     | in_data  (frame_in_t)
//  out     | result    | out_valid / out_stall   | out_data (frame_out_t)
//  cfg     | write     | cfg_write               | cfg_index, cfg_data
//
// A request is taken only while the lanes are free, and no new request is taken
// until the result has moved into the output register. The frame time is set by
// the bit-serial sweep index divider, which works out Q = clog2(2*COEFF_TABLE_DEPTH)
// + 1 quotient bits (12 at depth 1024), and by the stage walk, which passes a
// multiply state and an add state for each allpass stage.
// Both channels run side by side in their own lane; a mono frame runs left only.
// Reset clears all filter taps and loads the register defaults at once.
// A finished frame waits in the output register; a stall there holds the lanes
// in their done state only if the output register is still full.
`default_nettype none
`include "assert_macros.svh"
module stereo_allpass_phaser #(
    parameter int MAX_STAGES        = 12,
    parameter int COEFF_TABLE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sap_pkg::frame_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sap_pkg::frame_out_t               out_data,
    input  logic                              cfg_write,
    input  sap_pkg::cfg_reg_t                 cfg_index,
    input  logic [sap_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sap_pkg::*;

    localparam int CntW = $clog2(MAX_STAGES + 1);

    // configuration registers
    logic [17:0]        sample_rate_reg;
    logic [16:0]        min_hz_reg;
    logic [16:0]        max_hz_reg;
    logic [16:0]        wet_level_reg;
    logic signed [15:0] loop_gain_reg;
    logic               mix_mode_reg;
    logic [3:0]         stage_count_reg;
    logic [15:0]        loop_pole_reg;

    logic               busy_reg;
    logic               stereo_reg;
    logic               out_valid_reg;
    frame_out_t         out_data_reg;

    lane_cfg_t          lane_cfg;
    logic [CntW-1:0]    count_fix;
    logic [16:0]        wet_fix;
    lane_ctrl_t         lane_ctrl [2];
    lane_stat_t         lane_stat [2];
    logic signed [SAMPLE_BITS-1:0] lane_res [2];
    logic               accept;
    logic               out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= 18'd48000;
            min_hz_reg      <= 17'd200;
            max_hz_reg      <= 17'd2000;
            wet_level_reg   <= 17'd32768;
            loop_gain_reg   <= 16'sd0;
            mix_mode_reg    <= 1'b0;
            stage_count_reg <= 4'd4;
            loop_pole_reg   <= 16'd65364;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[17:0];
                REG_MIN_HZ:      min_hz_reg      <= cfg_data[16:0];
                REG_MAX_HZ:      max_hz_reg      <= cfg_data[16:0];
                REG_WET_LEVEL:   wet_level_reg   <= cfg_data[16:0];
                REG_LOOP_GAIN:   loop_gain_reg   <= cfg_data[15:0];
                REG_MIX_MODE:    mix_mode_reg    <= cfg_data[0];
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[3:0];
                REG_LOOP_POLE:   loop_pole_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Fix register ranges; the user must change config only while idle, the block itself does not enforce it.
    always_comb
    begin
        wet_fix = (wet_level_reg > UNITY_Q16) ? UNITY_Q16 : wet_level_reg;

        lane_cfg.fs     = (sample_rate_reg == 18'd0) ? RATE_DEFAULT : sample_rate_reg;
        lane_cfg.min_hz = min_hz_reg;
        lane_cfg.max_hz = max_hz_reg;
        lane_cfg.wet    = wet_fix;
        lane_cfg.dry    = mix_mode_reg ? UNITY_Q16 : 17'(UNITY_Q16 - wet_fix);
        lane_cfg.pole   = loop_pole_reg;
        if (loop_gain_reg > GAIN_LIMIT)
            lane_cfg.gain = GAIN_LIMIT;
        else if (loop_gain_reg < -GAIN_LIMIT)
            lane_cfg.gain = -GAIN_LIMIT;
        else
            lane_cfg.gain = loop_gain_reg;

        if (stage_count_reg == 4'd0)
            count_fix = CntW'(1);
        else if (int'(stage_count_reg) > MAX_STAGES)
            count_fix = CntW'(MAX_STAGES);
        else
            count_fix = CntW'(stage_count_reg);
    end

    // Take a frame only while the lanes are free; the output register
    // parts the two sides so a waiting result does not block the next frame.
    assign accept   = in_valid && !busy_reg;
    assign out_load = busy_reg && lane_stat[0].done && (!stereo_reg || lane_stat[1].done)
                      && (!out_valid_reg || !out_stall);

    always_comb
    begin
        lane_ctrl[0].start        = accept;
        lane_ctrl[1].start        = accept && in_data.stereo;
        lane_ctrl[0].release_lane = out_load;
        lane_ctrl[1].release_lane = out_load;
    end

    sap_lane #(
        .MAX_STAGES       (MAX_STAGES),
        .COEFF_TABLE_DEPTH(COEFF_TABLE_DEPTH)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (lane_cfg),
        .stage_count(count_fix),
        .ctrl       (lane_ctrl[0]),
        .sample     (in_data.sample_left),
        .lfo        (in_data.lfo_left),
        .stat       (lane_stat[0]),
        .result     (lane_res[0])
    );

    sap_lane #(
        .MAX_STAGES       (MAX_STAGES),
        .COEFF_TABLE_DEPTH(COEFF_TABLE_DEPTH)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (lane_cfg),
        .stage_count(count_fix),
        .ctrl       (lane_ctrl[1]),
        .sample     (in_data.sample_right),
        .lfo        (in_data.lfo_right),
        .stat       (lane_stat[1]),
        .result     (lane_res[1])
    );

    // Frame tracking: hold busy from accept until the result moves out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            stereo_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg   <= 1'b1;
            stereo_reg <= in_data.stereo;
        end
        else if (out_load)
            busy_reg <= 1'b0;
    end

    // Output register: merge the lanes, repeat left for a mono frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.out_left  <= lane_res[0];
            out_data_reg.out_right <= stereo_reg ? lane_res[1] : lane_res[0];
        end
    end

    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SAP_ASSERT_IMPLY(a_lanes_idle_when_free, clk, rst_n, !busy_reg, !lane_stat[0].active && !lane_stat[1].active)
    `SAP_ASSERT_IMPLY(a_mono_right_idle, clk, rst_n, busy_reg && !stereo_reg, !lane_stat[1].active)
    `SAP_ASSERT_NEXT(a_mono_copy, clk, rst_n, out_load && !stereo_reg, out_data_reg.out_right == out_data_reg.out_left)

endmodule
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench of the stereo allpass phaser: directed table, random frames, config sweeps.
`default_nettype none
module tb;
    import sap_pkg::*;

    localparam int     STAGE_SLOTS  = 12;
    localparam int     ROM_DEPTH    = 1024;
    localparam longint PI_FIXED     = 64'sd3373259426;
    localparam longint ONE_FIXED    = 64'sd1073741824;
    localparam int     SETTLE_WAIT  = 100;
    localparam int     PRESSURE_LEN = 3000;
    localparam longint CYCLE_LIMIT  = 2000000;
    localparam int     RANDOM_FRAMES = 1030;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    frame_in_t  in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    frame_out_t out_data;
    logic       cfg_write = 1'b0;
    cfg_reg_t   cfg_index = REG_SAMPLE_RATE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    stereo_allpass_phaser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file, held at the register widths
    logic [17:0]        sh_rate  = 18'd48000;
    logic [16:0]        sh_lo    = 17'd200;
    logic [16:0]        sh_hi    = 17'd2000;
    logic [16:0]        sh_wet   = 17'd32768;
    logic signed [15:0] sh_gain  = 16'sd0;
    logic               sh_mix   = 1'b0;
    logic [3:0]         sh_stages = 4'd4;
    logic [15:0]        sh_pole  = 16'd65364;

    // Shadow filter memory, indexed channel*STAGE_SLOTS + stage
    longint stage_x [2*STAGE_SLOTS];
    longint stage_z [2*STAGE_SLOTS];
    longint ret_in  [2];
    longint ret_out [2];
    longint tan_rom [ROM_DEPTH];

    frame_out_t pending_frames [$];
    int         mismatches = 0;
    longint     cycle_count = 0;
    bit         hold_request = 0;
    int         hold_left = 0;
    int         stall_run = 0;
    bit         stall_on = 1;

    function automatic longint round_shift(longint v, int s);
        // floor division of v + half: round to nearest, ties upward
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint top;
        top = (64'sd1 <<< (bits - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    function automatic longint mul_fixed(longint a, longint b);
        return (a * b) / ONE_FIXED;
    endfunction

    // Build the coefficient table: tan(theta) from truncated series of sin and cos
    function automatic void build_tan_rom();
        longint th;
        longint s_term;
        longint s_sum;
        longint c_term;
        longint c_sum;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            th = PI_FIXED / 4 - (PI_FIXED * k) / (2 * ROM_DEPTH);
            s_term = th;
            s_sum = th;
            c_term = ONE_FIXED;
            c_sum = ONE_FIXED;
            for (int n = 1; n <= 6; n++)
            begin
                s_term = -mul_fixed(mul_fixed(s_term, th), th) / ((2 * n) * (2 * n + 1));
                s_sum += s_term;
                c_term = -mul_fixed(mul_fixed(c_term, th), th) / ((2 * n - 1) * (2 * n));
                c_sum += c_term;
            end
            if (c_sum <= 0)
                c_sum = 1;
            tan_rom[k] = (s_sum * ONE_FIXED) / c_sum;
        end
    endfunction

    // Map an LFO value into the sweep and look up the allpass coefficient
    function automatic longint sweep_tan(longint lfo);
        longint fs;
        longint nyq;
        longint lo;
        longint hi;
        longint freq;
        longint k;
        fs = (sh_rate == 0) ? 48000 : longint'(sh_rate);
        nyq = fs * 49 / 100;
        if (nyq < 1)
            nyq = 1;
        lo = longint'(sh_lo);
        hi = longint'(sh_hi);
        lo = (lo < 1) ? 1 : ((lo > nyq) ? nyq : lo);
        hi = (hi < 1) ? 1 : ((hi > nyq) ? nyq : hi);
        if (lo > hi)
            lo = hi;
        freq = lo * 65536 + (hi - lo) * (lfo + 32768);
        k = (freq * 2 * ROM_DEPTH) / (fs * 65536);
        if (k > ROM_DEPTH - 1)
            k = ROM_DEPTH - 1;
        return tan_rom[k];
    endfunction

    // Feed, walk the allpass cascade and update the return high-pass of one channel
    function automatic longint walk_channel(longint x, int ch, longint c, longint g);
        int     n;
        int     idx;
        longint y;
        longint o;
        n = (sh_stages < 1) ? 1 : ((sh_stages > STAGE_SLOTS) ? STAGE_SLOTS : int'(sh_stages));
        y = clip(x + round_shift(g * ret_out[ch], 15), 32);
        for (int s = 0; s < n; s++)
        begin
            idx = ch * STAGE_SLOTS + s;
            o = clip(stage_x[idx] + round_shift(c * (stage_z[idx] - y), 30), 32);
            stage_x[idx] = y;
            stage_z[idx] = o;
            y = o;
        end
        o = clip(round_shift(longint'(sh_pole) * (ret_out[ch] + y - ret_in[ch]), 16), 32);
        ret_in[ch] = y;
        ret_out[ch] = o;
        return y;
    endfunction

    function automatic frame_out_t phaser_frame(frame_in_t f);
        frame_out_t r;
        longint wet;
        longint dry;
        longint g;
        longint x;
        longint y;
        wet = (sh_wet > 17'd65536) ? 65536 : longint'(sh_wet);
        dry = sh_mix ? 65536 : 65536 - wet;
        g = longint'(sh_gain);
        if (g > 31130)
            g = 31130;
        if (g < -31130)
            g = -31130;
        x = longint'(f.sample_left);
        y = walk_channel(x, 0, sweep_tan(longint'(f.lfo_left)), g);
        r.out_left = SAMPLE_BITS'(clip(round_shift(dry * x + wet * y, 16), SAMPLE_BITS));
        r.out_right = r.out_left;
        if (f.stereo)
        begin
            x = longint'(f.sample_right);
            y = walk_channel(x, 1, sweep_tan(longint'(f.lfo_right)), g);
            r.out_right = SAMPLE_BITS'(clip(round_shift(dry * x + wet * y, 16), SAMPLE_BITS));
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic frame_in_t random_frame();
        frame_in_t f;
        f.sample_left = pick_sample();
        f.sample_right = pick_sample();
        f.lfo_left = 16'($urandom);
        f.lfo_right = 16'($urandom);
        f.stereo = ($urandom_range(0, 3) != 0);
        return f;
    endfunction

    // Offer one request, hold it until accepted, then leave a random gap when idle is set.
    // The valid stays high across a zero gap, so it never gets two updates in a step.
    task automatic send_frame(frame_in_t f, bit typed, frame_out_t want, bit idle);
        frame_out_t guess;
        int gap;
        in_valid <= 1'b1;
        in_data <= f;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        guess = phaser_frame(f);
        pending_frames.push_back(typed ? want : guess);
        gap = idle ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain the block, let it settle, then write one register and the shadow copy
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SAMPLE_RATE: sh_rate = val[17:0];
            REG_MIN_HZ:      sh_lo = val[16:0];
            REG_MAX_HZ:      sh_hi = val[16:0];
            REG_WET_LEVEL:   sh_wet = val[16:0];
            REG_LOOP_GAIN:   sh_gain = val[15:0];
            REG_MIX_MODE:    sh_mix = val[0];
            REG_STAGE_COUNT: sh_stages = val[3:0];
            REG_LOOP_POLE:   sh_pole = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] v0, logic [CFG_DATA_W-1:0] v1,
                             logic [CFG_DATA_W-1:0] v2, logic [CFG_DATA_W-1:0] v3,
                             logic [CFG_DATA_W-1:0] v4, logic [CFG_DATA_W-1:0] v5,
                             logic [CFG_DATA_W-1:0] v6, logic [CFG_DATA_W-1:0] v7);
        write_reg(REG_SAMPLE_RATE, v0);
        write_reg(REG_MIN_HZ, v1);
        write_reg(REG_MAX_HZ, v2);
        write_reg(REG_WET_LEVEL, v3);
        write_reg(REG_LOOP_GAIN, v4);
        write_reg(REG_MIX_MODE, v5);
        write_reg(REG_STAGE_COUNT, v6);
        write_reg(REG_LOOP_POLE, v7);
    endtask

    // Directed rows: only the silent frame after reset carries a typed result
    typedef struct {
        frame_in_t  f;
        bit         typed;
        frame_out_t want;
    } stim_row_t;

    stim_row_t directed [] = '{
        '{'{24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1, '{24'sd0, 24'sd0}},
        '{'{24'sh7fffff, 24'sh800000, 16'sh7fff, 16'sh8000, 1'b1}, 1'b0, '0},
        '{'{24'sh800000, 24'sh7fffff, 16'sh8000, 16'sh7fff, 1'b1}, 1'b0, '0},
        '{'{24'sh7fffff, 24'sh7fffff, 16'sh7fff, 16'sh7fff, 1'b1}, 1'b0, '0},
        '{'{24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000, 1'b1}, 1'b0, '0},
        // mono: right fields carry junk and must be ignored
        '{'{24'sh123456, 24'sh7fffff, 16'sh4000, 16'sh8000, 1'b0}, 1'b0, '0},
        '{'{24'sh800000, 24'sh555555, 16'sh8000, 16'sh7fff, 1'b0}, 1'b0, '0},
        '{'{24'sh000001, 24'shffffff, 16'sh0000, 16'shffff, 1'b1}, 1'b0, '0},
        '{'{24'shffffff, 24'sh000001, 16'shffff, 16'sh0001, 1'b1}, 1'b0, '0},
        '{'{24'sh2aaaaa, 24'shd55555, 16'sh5555, 16'shaaaa, 1'b1}, 1'b0, '0},
        '{'{24'sh7fffff, 24'sh000000, 16'sh7fff, 16'sh0000, 1'b0}, 1'b0, '0},
        '{'{24'sh000000, 24'sh000000, 16'sh0000, 16'sh0000, 1'b1}, 1'b0, '0}
    };

    // Receiver: random stalls, plus one long hold-off to fill the block
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 0;
            hold_left = PRESSURE_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_run = stall_on && ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            out_stall <= (stall_run > 0);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        frame_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h", out_data.out_left, out_data.out_right);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (out_data.out_left !== want.out_left || out_data.out_right !== want.out_right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h, got %h %h", want.out_left,
                                 want.out_right, out_data.out_left, out_data.out_right);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        bit idle;
        foreach (stage_x[i])
        begin
            stage_x[i] = 0;
            stage_z[i] = 0;
        end
        ret_in = '{0, 0};
        ret_out = '{0, 0};
        build_tan_rom();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_frame(directed[i].f, directed[i].typed, directed[i].want, 1'b1);

        // Extremes: top rate, widest sweep, full wet at unity dry, max feedback
        write_all(18'd192000, 18'd1, 18'd94080, 18'd65536, 18'h079a, 18'd1, 18'd12, 18'd65535);
        write_reg(REG_LOOP_GAIN, 18'd31130);
        foreach (directed[i])
            send_frame(directed[i].f, 1'b0, '0, 1'b1);

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                // zero rate falls back to default, inverted sweep, stage count 0
                0: write_all(18'd0, 18'd5000, 18'd300, 18'd0, 18'h08000, 18'd0, 18'd0, 18'd0);
                // rate floor with clamped sweep, wet above unity, stage count above max
                1: write_all(18'd8000, 18'd94080, 18'h1ffff, 18'h1ffff, 18'h3ffff, 18'h3fffe,
                             18'd15, 18'hffff);
                2: write_all(18'h3ffff, 18'd1, 18'd1, 18'd32768, 18'h07fff, 18'd1, 18'd13,
                             18'd65364);
                3: write_all(18'd48000, 18'd200, 18'd2000, 18'd32768, 18'd0, 18'd0, 18'd4,
                             18'd65364);
                default:
                    write_all(18'($urandom_range(8000, 192000)), 18'($urandom_range(1, 20000)),
                              18'($urandom_range(1, 94080)), 18'($urandom), 18'($urandom),
                              18'($urandom), 18'($urandom_range(1, 12)), 18'($urandom));
            endcase
            stall_on = ($urandom_range(0, 3) != 0);
            idle = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < RANDOM_FRAMES / 7; n++)
            begin
                if (p == 4 && n == 20)
                    hold_request = 1;
                send_frame(random_frame(), 1'b0, '0, idle);
            end
        end
        in_valid <= 1'b0;

        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
